FILE: design/mldrt_pkg.sv
// shared types and codes for the listener table
package mldrt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_DONE   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_ADDED   = 2'd0,
    EV_REMOVED = 2'd1,
    EV_QUERY   = 2'd2,
    EV_FULL    = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_ENABLED  = 2'd0,
    REG_LISTENER = 2'd1,
    REG_LQI      = 2'd2,
    REG_LQC      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  iface;
    logic [63:0] group_high;
    logic [63:0] group_low;
    logic        checking;
    logic [23:0] leave;
    logic [15:0] requery;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  iface;
    logic [63:0] group_high;
    logic [63:0] group_low;
    logic [15:0] delay;
  } evt_t;

endpackage

FILE: design/mld_router_listener_table.sv
// router-side listener table: sequencer walking one entry ram
// a tick walks every entry; a report or done walks until its key matches or the last entry
// each ram entry is read in two steps (address, then evaluate); a full output holds the walk
// an idle or unknown item is taken without a walk; input is stalled while a walk runs
// results leave through one output register and one holding stage
// rst clears valid bits, sequencer and output; registers return to defaults
module mld_router_listener_table import mldrt_pkg::*; #(
  parameter int GROUP_ENTRIES   = 16,
  parameter int INTERFACE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [3:0]  iface,
  input  logic [63:0] group_high,
  input  logic [63:0] group_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [3:0]  out_iface,
  output logic [63:0] out_group_high,
  output logic [63:0] out_group_low,
  output logic [15:0] max_resp_delay,
  output logic        last_of_run
);
  localparam int IW = GROUP_ENTRIES > 1 ? $clog2(GROUP_ENTRIES) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_APPLY, S_FIN} state_t;

  state_t state;
  logic        enabled;
  logic [23:0] listener_interval;
  logic [15:0] lqi;
  logic [3:0]  lqc;

  logic [GROUP_ENTRIES-1:0] valid;
  logic [IW-1:0] idx, midx, fidx;
  logic hit, mchk, free_found;
  logic [1:0]  act_q;
  logic [3:0]  ifc_q;
  logic [63:0] gh_q, gl_q;
  logic [CNT_W-1:0] n;
  evt_t held;
  logic hv;

  entry_t rd, wr_data;
  logic wr_req, wr_en;
  logic [IW-1:0] wr_addr;
  logic ev_has, want, blocked, commit, clr_valid, set_valid, key_match, out_free, last_idx;
  logic out_load;
  evt_t ev_new;
  logic [19:0] prod;

  mldrt_ram #(.WIDTH($bits(entry_t)), .DEPTH(GROUP_ENTRIES)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(idx), .rd_data(rd)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign prod      = lqi * lqc;
  assign last_idx  = (idx == IW'(GROUP_ENTRIES - 1));
  assign key_match = valid[idx] && rd.iface == ifc_q && rd.group_high == gh_q
                     && rd.group_low == gl_q;
  // output register takes a new beat this cycle
  assign out_load  = (commit && want && hv) || (state == S_FIN && hv && out_free);

  always_comb begin
    ev_has    = 1'b0;
    ev_new    = '0;
    wr_req    = 1'b0;
    wr_data   = rd;
    wr_addr   = idx;
    clr_valid = 1'b0;
    set_valid = 1'b0;
    case (state)
      S_EVAL: begin
        if (act_q == ACT_TICK && valid[idx]) begin
          if (rd.leave <= 24'd1) begin
            ev_has    = 1'b1;
            ev_new    = '{EV_REMOVED, rd.iface, rd.group_high, rd.group_low, 16'd0};
            clr_valid = 1'b1;
          end else begin
            wr_req        = 1'b1;
            wr_data.leave = rd.leave - 24'd1;
            if (rd.checking) begin
              if (rd.requery <= 16'd1) begin
                ev_has          = 1'b1;
                ev_new          = '{EV_QUERY, rd.iface, rd.group_high, rd.group_low, lqi};
                wr_data.requery = lqi;
              end else begin
                wr_data.requery = rd.requery - 16'd1;
              end
            end
          end
        end
      end
      S_APPLY: begin
        if (act_q == ACT_REPORT) begin
          wr_data = '{ifc_q, gh_q, gl_q, 1'b0, listener_interval, 16'd0};
          if (hit) begin
            wr_req  = 1'b1;
            wr_addr = midx;
          end else if (free_found) begin
            wr_req    = 1'b1;
            wr_addr   = fidx;
            set_valid = 1'b1;
            ev_has    = 1'b1;
            ev_new    = '{EV_ADDED, ifc_q, gh_q, gl_q, 16'd0};
          end else begin
            ev_has = 1'b1;
            ev_new = '{EV_FULL, ifc_q, gh_q, gl_q, 16'd0};
          end
        end else if (hit && !mchk) begin
          wr_data = '{ifc_q, gh_q, gl_q, 1'b1, {4'd0, prod}, lqi};
          wr_req  = 1'b1;
          wr_addr = midx;
          ev_has  = 1'b1;
          ev_new  = '{EV_QUERY, ifc_q, gh_q, gl_q, lqi};
        end
      end
      default: ;
    endcase
    want    = ev_has && (n < CNT_W'(MAX_RESULTS));
    // a second event needs the held one pushed out first
    blocked = want && hv && !out_free;
    commit  = !blocked && (state == S_EVAL || state == S_APPLY);
    wr_en   = wr_req && commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      valid             <= '0;
      hv                <= 1'b0;
      out_valid         <= 1'b0;
      enabled           <= 1'b1;
      listener_interval <= 24'd260000;
      lqi               <= 16'd1000;
      lqc               <= 4'd2;
      n                 <= '0;
      idx               <= '0;
      hit               <= 1'b0;
      free_found        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_ENABLED:  enabled           <= cfg_data[0];
          REG_LISTENER: listener_interval <= cfg_data;
          REG_LQI:      lqi               <= cfg_data[15:0];
          REG_LQC:      lqc               <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (commit && want) begin
        if (hv) begin
          out_valid      <= 1'b1;
          event_kind     <= held.kind;
          out_iface      <= held.iface;
          out_group_high <= held.group_high;
          out_group_low  <= held.group_low;
          max_resp_delay <= held.delay;
          last_of_run    <= 1'b0;
        end
        held <= ev_new;
        hv   <= 1'b1;
        n    <= n + CNT_W'(1);
      end
      if (commit && clr_valid) begin
        valid[idx] <= 1'b0;
      end
      if (commit && set_valid) begin
        valid[fidx] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q      <= action;
            ifc_q      <= iface;
            gh_q       <= group_high;
            gl_q       <= group_low;
            idx        <= '0;
            n          <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            if (action == ACT_TICK) begin
              state <= S_READ;
            end else if ((action == ACT_REPORT || action == ACT_DONE) && enabled
                         && (32'(iface) < INTERFACE_COUNT)) begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (act_q == ACT_TICK) begin
            if (commit) begin
              if (last_idx) begin
                state <= S_FIN;
              end else begin
                idx   <= idx + IW'(1);
                state <= S_READ;
              end
            end
          end else if (key_match) begin
            hit   <= 1'b1;
            midx  <= idx;
            mchk  <= rd.checking;
            state <= S_APPLY;
          end else begin
            // remember the lowest free slot on the way
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              fidx       <= idx;
            end
            if (last_idx) begin
              state <= S_APPLY;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_READ;
            end
          end
        end
        S_APPLY: state <= S_FIN;
        S_FIN: begin
          if (!hv) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            event_kind     <= held.kind;
            out_iface      <= held.iface;
            out_group_high <= held.group_high;
            out_group_low  <= held.group_low;
            max_resp_delay <= held.delay;
            last_of_run    <= 1'b1;
            hv             <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/mldrt_ram.sv
// generic single write port ram with registered read
module mldrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: sim/tb_mld_router_listener_table.sv
// self-checking testbench for the router listener table
`timescale 1ns / 1ps

module tb_mld_router_listener_table import mldrt_pkg::*; ();

  localparam int N_ENTRIES = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  ifc;
    logic [63:0] gh;
    logic [63:0] gl;
    logic [15:0] delay;
    logic        last;
  } listener_event_t;

  // directed row: item plus optional typed-in result
  typedef struct packed {
    action_t     act;
    logic [3:0]  ifc;
    logic [63:0] gh;
    logic [63:0] gl;
    logic        typed;
    logic [1:0]  kind;
  } directed_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = REG_ENABLED;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = ACT_NONE;
  logic [3:0] iface = '0;
  logic [63:0] group_high = '0;
  logic [63:0] group_low = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] event_kind;
  logic [3:0] out_iface;
  logic [63:0] out_group_high, out_group_low;
  logic [15:0] max_resp_delay;
  logic last_of_run;

  mld_router_listener_table u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .iface(iface), .group_high(group_high), .group_low(group_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .out_iface(out_iface),
    .out_group_high(out_group_high), .out_group_low(out_group_low),
    .max_resp_delay(max_resp_delay), .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predicted table state and settings
  logic        tbl_valid [N_ENTRIES];
  logic [3:0]  tbl_ifc [N_ENTRIES];
  logic [63:0] tbl_gh [N_ENTRIES];
  logic [63:0] tbl_gl [N_ENTRIES];
  logic        tbl_checking [N_ENTRIES];
  logic [23:0] tbl_leave [N_ENTRIES];
  logic [15:0] tbl_requery [N_ENTRIES];
  logic        set_enabled;
  logic [23:0] set_listener;
  logic [15:0] set_lqi;
  logic [3:0]  set_lqc;

  listener_event_t pending_events[$];
  listener_event_t run_events[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int typed_row = -1;
  logic [1:0] typed_kind;

  task automatic add_event(input logic [1:0] k, input logic [3:0] f,
                           input logic [63:0] h, input logic [63:0] l,
                           input logic [15:0] d);
    listener_event_t ev;
    if (run_events.size() >= MAX_RESULTS) return;
    ev = '{kind: k, ifc: f, gh: h, gl: l, delay: d, last: 1'b0};
    run_events.push_back(ev);
  endtask

  task automatic predict_listener_events(input logic [1:0] act, input logic [3:0] f,
                                         input logic [63:0] h, input logic [63:0] l);
    int hit;
    int slot;
    run_events.delete();
    if (act == ACT_TICK) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!tbl_valid[i]) continue;
        if (tbl_leave[i] <= 24'd1) begin
          add_event(EV_REMOVED, tbl_ifc[i], tbl_gh[i], tbl_gl[i], '0);
          tbl_valid[i] = 0;
          tbl_checking[i] = 0;
          tbl_leave[i] = 0;
          tbl_requery[i] = 0;
          continue;
        end
        tbl_leave[i] = tbl_leave[i] - 24'd1;
        if (tbl_checking[i]) begin
          if (tbl_requery[i] <= 16'd1) begin
            add_event(EV_QUERY, tbl_ifc[i], tbl_gh[i], tbl_gl[i], set_lqi);
            tbl_requery[i] = set_lqi;
          end else tbl_requery[i] = tbl_requery[i] - 16'd1;
        end
      end
    end else if ((act == ACT_REPORT || act == ACT_DONE) && set_enabled) begin
      hit = -1;
      for (int i = 0; i < N_ENTRIES; i++)
        if (hit < 0 && tbl_valid[i] && tbl_ifc[i] == f && tbl_gh[i] == h && tbl_gl[i] == l)
          hit = i;
      if (act == ACT_REPORT) begin
        if (hit < 0) begin
          slot = -1;
          for (int i = 0; i < N_ENTRIES; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
          if (slot < 0) add_event(EV_FULL, f, h, l, '0);
          else begin
            tbl_valid[slot] = 1;
            tbl_ifc[slot] = f;
            tbl_gh[slot] = h;
            tbl_gl[slot] = l;
            tbl_requery[slot] = 0;
            add_event(EV_ADDED, f, h, l, '0);
            hit = slot;
          end
        end
        if (hit >= 0) begin
          tbl_checking[hit] = 0;
          tbl_leave[hit] = set_listener;
        end
      end else if (hit >= 0 && !tbl_checking[hit]) begin
        tbl_leave[hit] = 24'(set_lqi) * 24'(set_lqc);
        tbl_requery[hit] = set_lqi;
        tbl_checking[hit] = 1;
        add_event(EV_QUERY, f, h, l, set_lqi);
      end
    end
    if (run_events.size() > 0) run_events[run_events.size() - 1].last = 1;
    foreach (run_events[k]) pending_events.push_back(run_events[k]);
  endtask

  // output checker
  always @(posedge clk) begin
    listener_event_t exp_ev;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected beat kind=%0d iface=%0d", event_kind, out_iface);
        errors++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (event_kind !== exp_ev.kind) begin
          $error("event_kind expected %0d actual %0d", exp_ev.kind, event_kind); errors++;
        end
        if (out_iface !== exp_ev.ifc) begin
          $error("out_iface expected %0d actual %0d", exp_ev.ifc, out_iface); errors++;
        end
        if (out_group_high !== exp_ev.gh) begin
          $error("out_group_high expected %h actual %h", exp_ev.gh, out_group_high);
          errors++;
        end
        if (out_group_low !== exp_ev.gl) begin
          $error("out_group_low expected %h actual %h", exp_ev.gl, out_group_low);
          errors++;
        end
        if (max_resp_delay !== exp_ev.delay) begin
          $error("max_resp_delay expected %0d actual %0d", exp_ev.delay, max_resp_delay);
          errors++;
        end
        if (last_of_run !== exp_ev.last) begin
          $error("last_of_run expected %0d actual %0d", exp_ev.last, last_of_run); errors++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_write)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      REG_ENABLED:  set_enabled = val[0];
      REG_LISTENER: set_listener = val;
      REG_LQI:      set_lqi = val[15:0];
      REG_LQC:      set_lqc = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays up after the beat; the next item, an idle cycle or a drain drops it
  task automatic send_item(input logic [1:0] act, input logic [3:0] f,
                           input logic [63:0] h, input logic [63:0] l);
    logic [1:0] got_kind;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    iface <= f;
    group_high <= h;
    group_low <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_listener_events(act, f, h, l);
    got_kind = (run_events.size() == 0) ? 2'bxx : run_events[0].kind;
    if (typed_row >= 0 && (run_events.size() == 0 || run_events[0].kind !== typed_kind)) begin
      $error("directed row %0d event_kind expected %0d actual %0d",
             typed_row, typed_kind, got_kind);
      errors++;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  directed_row_t directed_rows[] = '{
    '{ACT_TICK,   4'd0,  64'd0, 64'd0, 1'b0, EV_ADDED},
    '{ACT_REPORT, 4'd0,  64'd0, 64'd0, 1'b1, EV_ADDED},
    '{ACT_REPORT, 4'd15, '1, '1, 1'b1, EV_ADDED},
    '{ACT_REPORT, 4'd15, '1, '1, 1'b0, EV_ADDED},
    '{ACT_DONE,   4'd15, '1, '1, 1'b1, EV_QUERY},
    '{ACT_DONE,   4'd15, '1, '1, 1'b0, EV_ADDED},
    '{ACT_DONE,   4'd3,  64'h5, 64'h6, 1'b0, EV_ADDED},
    '{ACT_NONE,   4'd1,  64'h1, 64'h2, 1'b0, EV_ADDED},
    '{ACT_TICK,   4'd0,  64'd0, 64'd0, 1'b0, EV_ADDED},
    '{ACT_TICK,   4'd0,  64'd0, 64'd0, 1'b1, EV_REMOVED},
    '{ACT_TICK,   4'd0,  64'd0, 64'd0, 1'b0, EV_ADDED}
  };

  task automatic fill_table();
    for (int i = 0; i < 17; i++) send_item(ACT_REPORT, 4'(i), rand64(), 64'(i));
  endtask

  initial begin
    set_enabled = 1; set_listener = 260000; set_lqi = 1000; set_lqc = 2;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 0; tbl_checking[i] = 0; tbl_leave[i] = 0; tbl_requery[i] = 0;
      tbl_ifc[i] = 0; tbl_gh[i] = 0; tbl_gl[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // short timers so expiry and re-query show up quickly
    write_reg(REG_LISTENER, 24'd3);
    write_reg(REG_LQI, 24'd1);
    write_reg(REG_LQC, 24'd2);
    foreach (directed_rows[r]) begin
      typed_row = directed_rows[r].typed ? r : -1;
      typed_kind = directed_rows[r].kind;
      send_item(directed_rows[r].act, directed_rows[r].ifc,
                directed_rows[r].gh, directed_rows[r].gl);
    end
    typed_row = -1;
    drain_results();

    // full table, busy tick, disabled messages
    write_reg(REG_LISTENER, 24'd1);
    fill_table();
    send_item(ACT_TICK, 4'd0, 64'd0, 64'd0);
    drain_results();
    write_reg(REG_ENABLED, 24'd0);
    send_item(ACT_REPORT, 4'd2, 64'h77, 64'h88);
    send_item(ACT_DONE, 4'd2, 64'h77, 64'h88);
    send_item(ACT_TICK, 4'd0, 64'd0, 64'd0);
    drain_results();
    write_reg(REG_ENABLED, 24'd1);
    write_reg(REG_LISTENER, 24'hFFFFFF);
    write_reg(REG_LQI, 24'hFFFF);
    write_reg(REG_LQC, 24'd15);
    send_item(ACT_REPORT, 4'd9, rand64(), rand64());
    send_item(ACT_DONE, 4'd9, 64'd0, 64'd0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      write_reg(REG_ENABLED, 24'($urandom_range(7) != 0));
      write_reg(REG_LISTENER, 24'($urandom_range(1, 12)));
      write_reg(REG_LQI, 24'($urandom_range(0, 4)));
      write_reg(REG_LQC, 24'($urandom_range(0, 15)));
      for (int n = 0; n < 60; n++) begin
        logic [1:0] act;
        logic [3:0] f;
        logic [63:0] h, l;
        int pick;
        pick = $urandom_range(99);
        act = (pick < 40) ? ACT_TICK : (pick < 70) ? ACT_REPORT :
              (pick < 95) ? ACT_DONE : ACT_NONE;
        // small key pool so reports and dones hit existing entries
        f = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
          h = rand64(); l = rand64();
        end else begin
          h = {{60{1'b1}}, 4'($urandom_range(3))};
          l = 64'($urandom_range(5));
        end
        send_item(act, f, h, l);
        if (n == 30) drain_results();
      end
      drain_results();
    end

    drain_results();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
